// ===== design/chme_pkg.sv =====
// Shared types, constants and codes of the color histogram model engine.
package chme_pkg;

    localparam int MAX_BIN_BITS_DEF   = 4;
    localparam int COUNT_WIDTH_DEF    = 24;
    localparam int PROB_FRAC_BITS_DEF = 24;

    localparam int CH_W       = 8;
    localparam int BINS_W     = 3;
    localparam int RATE_W     = 17;
    localparam int OUT_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_MAX_W  = 18;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BINS_W-1:0] BINS_RESET = 3'd4;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd13107;
    localparam logic [RATE_W-1:0] RATE_ONE   = 17'h10000;

    typedef enum logic [2:0] {
        OP_ADD_FG = 3'd0,
        OP_ADD_BG = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_UPDATE = 3'd3,
        OP_INIT   = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BINS    = 2'd0,
        CFG_RATE_FG = 2'd1,
        CFG_RATE_BG = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ADD,
        BK_LOOK,
        BK_WALK_RD,
        BK_DIV_LOAD,
        BK_DIV,
        BK_MUL,
        BK_SUM,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        t_op                  op;
        logic [IDX_MAX_W-1:0] idx;
    } t_queue_item;

    typedef struct packed {
        logic clearing;
        logic result_waiting;
    } t_back_status;

endpackage

// ===== design/chme_front.sv =====
// Front end: decode the operation and form the bin index of each accepted item.
module chme_front (
    input  logic                         i_valid,
    input  logic                         i_stall,
    input  logic [2:0]                   i_operation,
    input  logic [chme_pkg::CH_W-1:0]    i_channel_first,
    input  logic [chme_pkg::CH_W-1:0]    i_channel_second,
    input  logic [chme_pkg::CH_W-1:0]    i_channel_third,
    input  logic [chme_pkg::BINS_W-1:0]  i_bins,
    output logic                         o_push,
    output chme_pkg::t_queue_item        o_item
);

    logic        known_op;
    logic [3:0]  shift;
    logic [23:0] part_a;
    logic [23:0] part_b;
    logic [23:0] part_c;
    logic [23:0] idx_wide;

    always_comb begin
        unique case (chme_pkg::t_op'(i_operation))
            chme_pkg::OP_ADD_FG, chme_pkg::OP_ADD_BG, chme_pkg::OP_LOOKUP,
            chme_pkg::OP_UPDATE, chme_pkg::OP_INIT: known_op = 1'b1;
            default:                                known_op = 1'b0;
        endcase
    end

    assign shift    = 4'd8 - {1'b0, i_bins};
    assign part_a   = {16'd0, i_channel_first  >> shift};
    assign part_b   = {16'd0, i_channel_second >> shift};
    assign part_c   = {16'd0, i_channel_third  >> shift};
    assign idx_wide = (part_a << {i_bins, 1'b0}) | (part_b << i_bins) | part_c;

    // drop unknown codes here, they never reach the queue
    assign o_push     = i_valid && !i_stall && known_op;
    assign o_item.op  = chme_pkg::t_op'(i_operation);
    assign o_item.idx = idx_wide[chme_pkg::IDX_MAX_W-1:0];

endmodule

// ===== design/chme_queue.sv =====
// Short queue between front and back end.
module chme_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  chme_pkg::t_queue_item  i_item,
    input  logic                   i_pop,
    output logic                   o_valid,
    output logic                   o_full,
    output chme_pkg::t_queue_item  o_item
);

    localparam int PTR_W = $clog2(chme_pkg::QUEUE_DEPTH);

    chme_pkg::t_queue_item r_mem [chme_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(chme_pkg::QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(chme_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(chme_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== design/chme_back.sv =====
// Back end: count tables, model tables, bin walk with dividers and blend.
module chme_back #(
    parameter int MAX_BIN_BITS   = chme_pkg::MAX_BIN_BITS_DEF,
    parameter int COUNT_WIDTH    = chme_pkg::COUNT_WIDTH_DEF,
    parameter int PROB_FRAC_BITS = chme_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [chme_pkg::BINS_W-1:0]       i_bins,
    input  logic [chme_pkg::RATE_W-1:0]       i_rate_fg,
    input  logic [chme_pkg::RATE_W-1:0]       i_rate_bg,
    input  logic                              i_clear_req,
    input  logic                              i_q_valid,
    input  chme_pkg::t_queue_item             i_q_item,
    output logic                              o_q_pop,
    output chme_pkg::t_back_status            o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [chme_pkg::OUT_W-1:0]        o_prob_fg,
    output logic [chme_pkg::OUT_W-1:0]        o_prob_bg,
    output logic                              o_result_kind
);

    localparam int IDX_W = 3 * MAX_BIN_BITS;
    localparam int DEPTH = 1 << IDX_W;
    localparam int CW    = COUNT_WIDTH;
    localparam int MW    = PROB_FRAC_BITS + 1;
    localparam int QB    = MW;
    localparam int NW    = CW + PROB_FRAC_BITS + 1;
    localparam int SW    = $clog2(QB);
    localparam int PW    = chme_pkg::RATE_W + MW;
    localparam int AW    = PW + 1;
    localparam int RW    = chme_pkg::RATE_W;

    logic [CW-1:0] cnt_fg_mem [DEPTH];
    logic [CW-1:0] cnt_bg_mem [DEPTH];
    logic [MW-1:0] mdl_fg_mem [DEPTH];
    logic [MW-1:0] mdl_bg_mem [DEPTH];

    chme_pkg::t_back_state r_state, n_state;

    logic [IDX_W-1:0] r_clr;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_idx;
    chme_pkg::t_op    r_op;
    logic [CW-1:0]    r_total_fg, r_total_bg;
    logic [SW-1:0]    r_step;
    logic             r_out_valid;
    logic [chme_pkg::OUT_W-1:0] r_prob_fg, r_prob_bg;
    logic             r_kind;

    logic [CW-1:0]    r_cnt_fg_rd, r_cnt_bg_rd;
    logic [MW-1:0]    r_mdl_fg_rd, r_mdl_bg_rd;
    logic [RW-1:0]    r_rate_fg, r_rate_bg;
    logic             r_act_fg, r_act_bg, r_uni_fg, r_uni_bg;
    logic [CW-1:0]    r_rem_fg, r_rem_bg;
    logic [QB-1:0]    r_low_fg, r_low_bg;
    logic [PW-1:0]    r_p1_fg, r_p2_fg, r_p1_bg, r_p2_bg;

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             cnt_fg_we, cnt_bg_we, mdl_fg_we, mdl_bg_we;
    logic [CW-1:0]    cnt_fg_wd, cnt_bg_wd;
    logic [MW-1:0]    mdl_fg_wd, mdl_bg_wd;
    logic             out_load, out_kind, slot_free;

    logic [MW-1:0]    uniform;
    logic [IDX_W:0]   bin_count;
    logic [IDX_W-1:0] last_bin;
    logic [IDX_W-1:0] q_idx;
    logic [CW-1:0]    cnt_max;
    logic [NW-1:0]    num_fg, num_bg;
    logic [CW:0]      trial_fg, trial_bg, diff_fg, diff_bg;
    logic             ge_fg, ge_bg;
    logic [RW-1:0]    rate_fg_clamped, rate_bg_clamped;
    logic [AW-1:0]    acc_fg, acc_bg;
    logic [MW-1:0]    blend_fg, blend_bg;
    logic [MW+chme_pkg::OUT_W-1:0] look_fg_ext, look_bg_ext;

    assign uniform   = (MW'(1) << PROB_FRAC_BITS) >> (3 * i_bins);
    assign bin_count = (IDX_W+1)'(1) << (3 * i_bins);
    assign last_bin  = IDX_W'(bin_count - (IDX_W+1)'(1));
    assign q_idx     = i_q_item.idx[IDX_W-1:0];
    assign cnt_max   = '1;
    assign slot_free = !r_out_valid || !i_out_stall;

    assign rate_fg_clamped = (i_rate_fg > chme_pkg::RATE_ONE) ? chme_pkg::RATE_ONE : i_rate_fg;
    assign rate_bg_clamped = (i_rate_bg > chme_pkg::RATE_ONE) ? chme_pkg::RATE_ONE : i_rate_bg;

    // divider numerators: count scaled to probability plus half the total
    assign num_fg = NW'({r_cnt_fg_rd, PROB_FRAC_BITS'(0)}) + NW'(r_total_fg >> 1);
    assign num_bg = NW'({r_cnt_bg_rd, PROB_FRAC_BITS'(0)}) + NW'(r_total_bg >> 1);

    assign trial_fg = {r_rem_fg, r_low_fg[QB-1]};
    assign trial_bg = {r_rem_bg, r_low_bg[QB-1]};
    assign ge_fg    = (trial_fg >= {1'b0, r_total_fg});
    assign ge_bg    = (trial_bg >= {1'b0, r_total_bg});
    assign diff_fg  = trial_fg - {1'b0, r_total_fg};
    assign diff_bg  = trial_bg - {1'b0, r_total_bg};

    assign acc_fg   = AW'(r_p1_fg) + AW'(r_p2_fg) + AW'(32768);
    assign acc_bg   = AW'(r_p1_bg) + AW'(r_p2_bg) + AW'(32768);
    assign blend_fg = acc_fg[16 +: MW];
    assign blend_bg = acc_bg[16 +: MW];

    assign look_fg_ext = {(chme_pkg::OUT_W)'(0), r_mdl_fg_rd};
    assign look_bg_ext = {(chme_pkg::OUT_W)'(0), r_mdl_bg_rd};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chme_pkg::BK_CLEAR:    if (r_clr == '1) n_state = chme_pkg::BK_IDLE;
            chme_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        chme_pkg::OP_ADD_FG, chme_pkg::OP_ADD_BG:
                            n_state = chme_pkg::BK_ADD;
                        chme_pkg::OP_LOOKUP:
                            n_state = chme_pkg::BK_LOOK;
                        chme_pkg::OP_UPDATE, chme_pkg::OP_INIT:
                            n_state = chme_pkg::BK_WALK_RD;
                        default:
                            n_state = chme_pkg::BK_IDLE;
                    endcase
                end
            end
            chme_pkg::BK_ADD:      n_state = chme_pkg::BK_IDLE;
            chme_pkg::BK_LOOK:     if (slot_free) n_state = chme_pkg::BK_IDLE;
            chme_pkg::BK_WALK_RD:  n_state = chme_pkg::BK_DIV_LOAD;
            chme_pkg::BK_DIV_LOAD: n_state = chme_pkg::BK_DIV;
            chme_pkg::BK_DIV:      if (r_step == SW'(QB - 1)) n_state = chme_pkg::BK_MUL;
            chme_pkg::BK_MUL:      n_state = chme_pkg::BK_SUM;
            chme_pkg::BK_SUM: begin
                n_state = (r_i == last_bin) ? chme_pkg::BK_DONE : chme_pkg::BK_WALK_RD;
            end
            chme_pkg::BK_DONE:     if (slot_free) n_state = chme_pkg::BK_IDLE;
            default:               n_state = chme_pkg::BK_CLEAR;
        endcase
        if (i_clear_req) begin
            n_state = chme_pkg::BK_CLEAR;
        end
    end

    // outputs of the sequencer
    always_comb begin
        rd_addr   = r_idx;
        wr_addr   = r_i;
        cnt_fg_we = 1'b0;
        cnt_bg_we = 1'b0;
        mdl_fg_we = 1'b0;
        mdl_bg_we = 1'b0;
        cnt_fg_wd = '0;
        cnt_bg_wd = '0;
        mdl_fg_wd = uniform;
        mdl_bg_wd = uniform;
        o_q_pop   = 1'b0;
        out_load  = 1'b0;
        out_kind  = 1'b0;
        unique case (r_state)
            chme_pkg::BK_CLEAR: begin
                wr_addr   = r_clr;
                cnt_fg_we = 1'b1;
                cnt_bg_we = 1'b1;
                mdl_fg_we = 1'b1;
                mdl_bg_we = 1'b1;
            end
            chme_pkg::BK_IDLE: begin
                rd_addr = q_idx;
                o_q_pop = i_q_valid && !i_clear_req;
            end
            chme_pkg::BK_ADD: begin
                wr_addr   = r_idx;
                cnt_fg_we = (r_op == chme_pkg::OP_ADD_FG);
                cnt_bg_we = (r_op == chme_pkg::OP_ADD_BG);
                cnt_fg_wd = (r_cnt_fg_rd == cnt_max) ? r_cnt_fg_rd : r_cnt_fg_rd + CW'(1);
                cnt_bg_wd = (r_cnt_bg_rd == cnt_max) ? r_cnt_bg_rd : r_cnt_bg_rd + CW'(1);
            end
            chme_pkg::BK_LOOK: begin
                out_load = slot_free;
            end
            chme_pkg::BK_WALK_RD, chme_pkg::BK_DIV_LOAD, chme_pkg::BK_DIV,
            chme_pkg::BK_MUL: begin
                rd_addr = r_i;
            end
            chme_pkg::BK_SUM: begin
                rd_addr   = r_i;
                cnt_fg_we = 1'b1;
                cnt_bg_we = 1'b1;
                mdl_fg_we = r_act_fg || r_uni_fg;
                mdl_bg_we = r_act_bg || r_uni_bg;
                mdl_fg_wd = r_act_fg ? blend_fg : uniform;
                mdl_bg_wd = r_act_bg ? blend_bg : uniform;
            end
            chme_pkg::BK_DONE: begin
                out_load = slot_free;
                out_kind = 1'b1;
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (cnt_fg_we) cnt_fg_mem[wr_addr] <= cnt_fg_wd;
        if (cnt_bg_we) cnt_bg_mem[wr_addr] <= cnt_bg_wd;
        if (mdl_fg_we) mdl_fg_mem[wr_addr] <= mdl_fg_wd;
        if (mdl_bg_we) mdl_bg_mem[wr_addr] <= mdl_bg_wd;
        r_cnt_fg_rd <= cnt_fg_mem[rd_addr];
        r_cnt_bg_rd <= cnt_bg_mem[rd_addr];
        r_mdl_fg_rd <= mdl_fg_mem[rd_addr];
        r_mdl_bg_rd <= mdl_bg_mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chme_pkg::BK_CLEAR;
            r_clr       <= '0;
            r_i         <= '0;
            r_step      <= '0;
            r_total_fg  <= '0;
            r_total_bg  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_clear_req) begin
                r_clr      <= '0;
                r_total_fg <= '0;
                r_total_bg <= '0;
            end else begin
                unique case (r_state)
                    chme_pkg::BK_CLEAR: r_clr <= r_clr + IDX_W'(1);
                    chme_pkg::BK_IDLE:  r_i   <= '0;
                    chme_pkg::BK_ADD: begin
                        if (r_op == chme_pkg::OP_ADD_FG && r_total_fg != cnt_max) begin
                            r_total_fg <= r_total_fg + CW'(1);
                        end
                        if (r_op == chme_pkg::OP_ADD_BG && r_total_bg != cnt_max) begin
                            r_total_bg <= r_total_bg + CW'(1);
                        end
                    end
                    chme_pkg::BK_DIV_LOAD: r_step <= '0;
                    chme_pkg::BK_DIV:      r_step <= r_step + SW'(1);
                    chme_pkg::BK_SUM:      r_i    <= r_i + IDX_W'(1);
                    chme_pkg::BK_DONE: begin
                        if (slot_free) begin
                            r_total_fg <= '0;
                            r_total_bg <= '0;
                        end
                    end
                    default: r_step <= r_step;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_idx    <= q_idx;
            r_op     <= i_q_item.op;
            r_act_fg <= (r_total_fg != '0);
            r_act_bg <= (r_total_bg != '0);
            if (i_q_item.op == chme_pkg::OP_INIT) begin
                r_rate_fg <= chme_pkg::RATE_ONE;
                r_rate_bg <= chme_pkg::RATE_ONE;
                r_uni_fg  <= (r_total_fg == '0);
                r_uni_bg  <= (r_total_bg == '0);
            end else begin
                r_rate_fg <= rate_fg_clamped;
                r_rate_bg <= rate_bg_clamped;
                r_uni_fg  <= (r_total_fg == '0) && (rate_fg_clamped == chme_pkg::RATE_ONE);
                r_uni_bg  <= (r_total_bg == '0) && (rate_bg_clamped == chme_pkg::RATE_ONE);
            end
        end
        if (r_state == chme_pkg::BK_DIV_LOAD) begin
            r_rem_fg <= num_fg[NW-1:QB];
            r_low_fg <= num_fg[QB-1:0];
            r_rem_bg <= num_bg[NW-1:QB];
            r_low_bg <= num_bg[QB-1:0];
        end else if (r_state == chme_pkg::BK_DIV) begin
            r_rem_fg <= ge_fg ? diff_fg[CW-1:0] : trial_fg[CW-1:0];
            r_low_fg <= {r_low_fg[QB-2:0], ge_fg};
            r_rem_bg <= ge_bg ? diff_bg[CW-1:0] : trial_bg[CW-1:0];
            r_low_bg <= {r_low_bg[QB-2:0], ge_bg};
        end
        if (r_state == chme_pkg::BK_MUL) begin
            r_p1_fg <= (chme_pkg::RATE_ONE - r_rate_fg) * r_mdl_fg_rd;
            r_p2_fg <= r_rate_fg * r_low_fg;
            r_p1_bg <= (chme_pkg::RATE_ONE - r_rate_bg) * r_mdl_bg_rd;
            r_p2_bg <= r_rate_bg * r_low_bg;
        end
        if (out_load) begin
            r_kind    <= out_kind;
            r_prob_fg <= out_kind ? '0 : look_fg_ext[chme_pkg::OUT_W-1:0];
            r_prob_bg <= out_kind ? '0 : look_bg_ext[chme_pkg::OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_prob_fg     = r_prob_fg;
    assign o_prob_bg     = r_prob_bg;
    assign o_result_kind = r_kind;

    assign o_status.clearing       = (r_state == chme_pkg::BK_CLEAR);
    assign o_status.result_waiting = r_out_valid;

endmodule

// ===== design/color_histogram_model_engine.sv =====
// Top level of the color histogram model engine: registers, front, queue, back.
//
// Pixel items are binned by the top bins_log2 bits of each channel; add items
// pass through a count read and a saturating write in the back end, and a
// lookup reads the models and then waits on any output stall. Frame update and
// initialize walk the 2^(3*bins_log2) active bins through a shared bit-serial
// divider pair, one quotient bit a cycle; each bin is read, loaded into the
// dividers, divided, multiplied and blended back. A two-entry queue parts the
// front from the back, and a registered output slot lets the back move on
// while a result waits. After reset, and after every bins_log2 write, a
// clearing pass over all 2^(3*MAX_BIN_BITS) entries (4096 by default) zeroes
// the counts and loads uniform models; input items stall meanwhile while
// configuration writes are still taken.
module color_histogram_model_engine #(
    parameter int MAX_BIN_BITS   = chme_pkg::MAX_BIN_BITS_DEF,
    parameter int COUNT_WIDTH    = chme_pkg::COUNT_WIDTH_DEF,
    parameter int PROB_FRAC_BITS = chme_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_operation,
    input  logic [chme_pkg::CH_W-1:0]           i_channel_first,
    input  logic [chme_pkg::CH_W-1:0]           i_channel_second,
    input  logic [chme_pkg::CH_W-1:0]           i_channel_third,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [chme_pkg::OUT_W-1:0]          o_prob_foreground,
    output logic [chme_pkg::OUT_W-1:0]          o_prob_background,
    output logic                                o_result_kind,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [chme_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [chme_pkg::RATE_W-1:0]         i_cfg_data
);

    localparam logic [chme_pkg::BINS_W-1:0] BINS_MAX = chme_pkg::BINS_W'(MAX_BIN_BITS);

    logic [chme_pkg::BINS_W-1:0] r_bins;
    logic [chme_pkg::RATE_W-1:0] r_rate_fg;
    logic [chme_pkg::RATE_W-1:0] r_rate_bg;
    logic                        r_clear_req;

    logic                        cfg_we;
    logic [chme_pkg::BINS_W-1:0] bins_clamped;
    logic                        push;
    logic                        pop;
    logic                        q_valid;
    logic                        q_full;
    chme_pkg::t_queue_item       front_item;
    chme_pkg::t_queue_item       q_item;
    chme_pkg::t_back_status      back_status;

    // registers are always writable; the user writes them only while idle
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // clamp bins_log2 into 1..MAX_BIN_BITS
    always_comb begin
        bins_clamped = i_cfg_data[chme_pkg::BINS_W-1:0];
        if (bins_clamped == '0) begin
            bins_clamped = chme_pkg::BINS_W'(1);
        end else if (bins_clamped > BINS_MAX) begin
            bins_clamped = BINS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins      <= (chme_pkg::BINS_RESET > BINS_MAX) ? BINS_MAX : chme_pkg::BINS_RESET;
            r_rate_fg   <= chme_pkg::RATE_RESET;
            r_rate_bg   <= chme_pkg::RATE_RESET;
            r_clear_req <= 1'b0;
        end else begin
            r_clear_req <= 1'b0;
            if (cfg_we) begin
                case (chme_pkg::t_cfg_index'(i_cfg_index))
                    chme_pkg::CFG_BINS: begin
                        r_bins      <= bins_clamped;
                        r_clear_req <= 1'b1;
                    end
                    chme_pkg::CFG_RATE_FG: r_rate_fg <= i_cfg_data;
                    chme_pkg::CFG_RATE_BG: r_rate_bg <= i_cfg_data;
                    default:               r_clear_req <= 1'b0;
                endcase
            end
        end
    end

    // hold input while the queue is full or a clearing pass is pending or running
    assign o_in_stall = q_full || back_status.clearing || r_clear_req;

    chme_front u_front (
        .i_valid          (i_in_valid),
        .i_stall          (o_in_stall),
        .i_operation      (i_operation),
        .i_channel_first  (i_channel_first),
        .i_channel_second (i_channel_second),
        .i_channel_third  (i_channel_third),
        .i_bins           (r_bins),
        .o_push           (push),
        .o_item           (front_item)
    );

    chme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    chme_back #(
        .MAX_BIN_BITS   (MAX_BIN_BITS),
        .COUNT_WIDTH    (COUNT_WIDTH),
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bins        (r_bins),
        .i_rate_fg     (r_rate_fg),
        .i_rate_bg     (r_rate_bg),
        .i_clear_req   (r_clear_req),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (pop),
        .o_status      (back_status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_prob_fg     (o_prob_foreground),
        .o_prob_bg     (o_prob_background),
        .o_result_kind (o_result_kind)
    );

endmodule

// ===== design/chme_checker.sv =====
// Port-level checker of the color histogram model engine, bound to the top level.
module chme_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_stall,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [chme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [chme_pkg::OUT_W-1:0]         o_prob_foreground,
    input logic [chme_pkg::OUT_W-1:0]         o_prob_background,
    input logic                               o_result_kind
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_prob_foreground)
            && $stable(o_prob_background) && $stable(o_result_kind))
        else $error("result payload changed while stalled");

    // update completion carries zero probabilities
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_prob_foreground == '0
            && o_prob_background == '0)
        else $error("update result with nonzero payload");

    // a bins write starts a clearing pass that holds off input
    a_bins_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && i_cfg_index == chme_pkg::CFG_BINS |=> o_in_stall)
        else $error("input not held after bins write");

endmodule

bind color_histogram_model_engine chme_checker u_chme_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .i_cfg_valid       (i_cfg_valid),
    .o_cfg_ready       (o_cfg_ready),
    .i_cfg_index       (i_cfg_index),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_prob_foreground (o_prob_foreground),
    .o_prob_background (o_prob_background),
    .o_result_kind     (o_result_kind)
);
